// ===== design/bcd_rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_rtc_pkg : shared types and constants for the BCD real-time clock
// Stream packing, operation codes and timer state used across the block.
// ----------------------------------------------------------------------------
package bcd_rtc_pkg;

  // prescaler restart point: one second of 32768 Hz reference ticks
  localparam int unsigned PRESCALE_PERIOD = 32768;
  localparam int unsigned PRESCALE_W      = 15;

  localparam int unsigned ITEM_W    = 97;
  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned RESULT_W  = 50;
  localparam int unsigned M_TDATA_W = 56;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_TIME  = 2'd1,
    OP_SET_DATE  = 2'd2,
    OP_SET_TIMER = 2'd3
  } op_t;

  // input payload, last field in the low bits
  typedef struct packed {
    logic        retrigger_in;
    logic        enable_in;
    logic [31:0] target_in;
    logic [23:0] date_in;
    logic [14:0] prescale_start;
    logic [23:0] time_in;
  } item_t;

  typedef struct packed {
    logic        timer_running;
    logic        timer_fired;
    logic [23:0] date_out;
    logic [23:0] time_out;
  } result_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] target;
    logic        on;
    logic        periodic;
  } tmr_state_t;

endpackage

// ===== design/bcd_rtc_cal.sv =====
// ----------------------------------------------------------------------------
// bcd_rtc_cal : one-second advance of BCD time and date
// Carries digit by digit through seconds, minutes, hours, days, months, years.
// ----------------------------------------------------------------------------
module bcd_rtc_cal (
  input  logic [23:0] time_cur,
  input  logic [23:0] date_cur,
  output logic [23:0] time_adv,
  output logic [23:0] date_adv
);

  // digit increment, wraps mod 16; carry when it lands exactly on lim
  function automatic logic [4:0] nib_inc(input logic [3:0] d, input logic [4:0] lim);
    logic [3:0] v;
    v = d + 4'd1;
    if ({1'b0, v} == lim) begin
      nib_inc = {1'b1, 4'd0};
    end else begin
      nib_inc = {1'b0, v};
    end
  endfunction

  function automatic logic [7:0] to_bin(input logic [3:0] tens, input logic [3:0] units);
    to_bin = 8'(tens) * 8'd10 + 8'(units);
  endfunction

  logic [23:0] t;
  logic [23:0] d;
  logic [4:0]  r;
  logic [7:0]  month;
  logic [7:0]  days_p1;
  logic        hour_carry;

  always_comb begin
    t          = time_cur;
    d          = date_cur;
    month      = to_bin(date_cur[15:12], date_cur[11:8]);
    days_p1    = 8'd31;
    hour_carry = 1'b0;

    r = nib_inc(t[3:0], 5'd10);
    t[3:0] = r[3:0];
    if (r[4]) begin
      r = nib_inc(t[7:4], 5'd6);
      t[7:4] = r[3:0];
      if (r[4]) begin
        r = nib_inc(t[11:8], 5'd10);
        t[11:8] = r[3:0];
        if (r[4]) begin
          r = nib_inc(t[15:12], 5'd6);
          t[15:12] = r[3:0];
          if (r[4]) begin
            r = nib_inc(t[19:16], 5'd10);
            t[19:16] = r[3:0];
            if (r[4]) begin
              t[23:20] = t[23:20] + 4'd1;
            end
            hour_carry = (to_bin(t[23:20], t[19:16]) == 8'd24);
          end
        end
      end
    end

    // month length plus one, taken from the month before any roll
    if (month == 8'd1 || month == 8'd3 || month == 8'd5 || month == 8'd7 ||
        month == 8'd8 || month == 8'd10 || month == 8'd12) begin
      days_p1 = 8'd32;
    end else if (month == 8'd2) begin
      days_p1 = 8'd29;
    end else begin
      days_p1 = 8'd31;
    end

    if (hour_carry) begin
      t[23:16] = 8'h00;
      r = nib_inc(d[3:0], 5'd10);
      d[3:0] = r[3:0];
      if (r[4]) begin
        d[7:4] = d[7:4] + 4'd1;
      end
      if (to_bin(d[7:4], d[3:0]) == days_p1) begin
        d[7:0] = 8'h01;
        r = nib_inc(d[11:8], 5'd10);
        d[11:8] = r[3:0];
        if (r[4]) begin
          d[15:12] = d[15:12] + 4'd1;
        end
        if (to_bin(d[15:12], d[11:8]) == 8'd13) begin
          d[15:8] = 8'h01;
          r = nib_inc(d[19:16], 5'd10);
          d[19:16] = r[3:0];
          if (r[4]) begin
            r = nib_inc(d[23:20], 5'd10);
            d[23:20] = r[3:0];
          end
        end
      end
    end

    time_adv = t;
    date_adv = d;
  end

endmodule

// ===== design/bcd_rtc_tmr.sv =====
// ----------------------------------------------------------------------------
// bcd_rtc_tmr : tick timer next-state logic
// Counts ticks toward the target, fires on a match, handles timer writes.
// ----------------------------------------------------------------------------
module bcd_rtc_tmr (
  input  logic                   is_tick,
  input  logic                   is_set,
  input  logic [31:0]            target_in,
  input  logic                   enable_in,
  input  logic                   retrigger_in,
  input  bcd_rtc_pkg::tmr_state_t cur,
  output bcd_rtc_pkg::tmr_state_t nxt,
  output logic                   fired
);
  import bcd_rtc_pkg::*;

  logic [31:0] count_inc;

  assign count_inc = cur.count + 32'd1;

  always_comb begin
    nxt   = cur;
    fired = 1'b0;
    if (is_set) begin
      nxt.target   = target_in;
      nxt.on       = enable_in;
      nxt.periodic = retrigger_in;
      nxt.count    = 32'd0;
    end else if (is_tick && cur.on) begin
      if (count_inc == cur.target) begin
        nxt.count = 32'd0;
        nxt.on    = cur.periodic;
        fired     = 1'b1;
      end else begin
        nxt.count = count_inc;
      end
    end
  end

endmodule

// ===== design/bcd_rtc_calendar_timer_top.sv =====
// ----------------------------------------------------------------------------
// bcd_rtc_calendar_timer_top : BCD real-time clock, calendar and tick timer
// Stream-in operations, one status transaction out per operation.
// ----------------------------------------------------------------------------
// Each input transaction is one operation chosen by s_axis_tuser: a 32768 Hz
// reference tick, a time write (with prescaler start value), a date write, or
// a timer write (target, enable, periodic mode; clears the tick count). Every
// operation returns exactly one output transaction carrying the time and date
// after the operation, the timer-fired flag (ticks only) and the timer enable.
// Throughput is one transaction per clock while m_axis_tready drains the output.
// An accepted input is held in the input register, then the calendar carry
// chain and timer compare resolve in a single pass into the state and output
// registers, which drive m_axis_tvalid and m_axis_tdata.
// While a result waits for m_axis_tready the input register can still take one
// more transaction. Time and date are BCD, packed hh mm ss and yy mm dd with
// the units digit in the low nibble of each pair.
// No leap years: February is always 28 days, months outside 1..12 take 30,
// and the year wraps from 99 to 00. Non-BCD digits wrap modulo 16 and carry
// only on an exact limit. Synchronous reset zeroes all but the data registers.
// ----------------------------------------------------------------------------
module bcd_rtc_calendar_timer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // time_in[23:0], prescale_start[38:24], date_in[62:39], target_in[94:63],
  // enable_in[95], retrigger_in[96], zero pad above
  input  logic [bcd_rtc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op[1:0]
  input  logic [bcd_rtc_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // time_out[23:0], date_out[47:24], timer_fired[48], timer_running[49],
  // zero pad above
  output logic [bcd_rtc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import bcd_rtc_pkg::*;

  // input register
  logic   in_valid;
  op_t    in_op;
  item_t  in_item;
  logic   proc;

  // architectural state
  logic [PRESCALE_W-1:0] prescaler;
  logic [PRESCALE_W-1:0] prescaler_next;
  logic [23:0]           time_digits;
  logic [23:0]           time_digits_next;
  logic [23:0]           date_digits;
  logic [23:0]           date_digits_next;
  tmr_state_t            tmr;
  tmr_state_t            tmr_next;

  // output register
  logic    out_valid;
  result_t out_data;

  logic [PRESCALE_W:0]   pre_inc;
  logic                  pre_wrap;
  logic [23:0]           time_adv;
  logic [23:0]           date_adv;
  logic                  fired;

  // advance an item when the output slot is free or being drained
  assign proc          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= op_t'(s_axis_tuser);
      in_item <= item_t'(s_axis_tdata[ITEM_W-1:0]);
    end
  end

  // prescaler: reaching the period restarts it and advances one second
  assign pre_inc  = {1'b0, prescaler} + {{PRESCALE_W{1'b0}}, 1'b1};
  assign pre_wrap = (pre_inc >= (PRESCALE_W+1)'(PRESCALE_PERIOD));

  bcd_rtc_cal u_cal (
    .time_cur (time_digits),
    .date_cur (date_digits),
    .time_adv (time_adv),
    .date_adv (date_adv)
  );

  // timer is served before the prescaler within a tick
  bcd_rtc_tmr u_tmr (
    .is_tick      (in_op == OP_TICK),
    .is_set       (in_op == OP_SET_TIMER),
    .target_in    (in_item.target_in),
    .enable_in    (in_item.enable_in),
    .retrigger_in (in_item.retrigger_in),
    .cur          (tmr),
    .nxt          (tmr_next),
    .fired        (fired)
  );

  always_comb begin
    prescaler_next   = prescaler;
    time_digits_next = time_digits;
    date_digits_next = date_digits;
    unique case (in_op)
      OP_TICK: begin
        if (pre_wrap) begin
          prescaler_next   = '0;
          time_digits_next = time_adv;
          date_digits_next = date_adv;
        end else begin
          prescaler_next = pre_inc[PRESCALE_W-1:0];
        end
      end
      OP_SET_TIME: begin
        time_digits_next = in_item.time_in;
        prescaler_next   = in_item.prescale_start;
      end
      OP_SET_DATE: begin
        date_digits_next = in_item.date_in;
      end
      OP_SET_TIMER: begin
        // timer fields handled in u_tmr
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler   <= '0;
      time_digits <= '0;
      date_digits <= '0;
      tmr         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (proc) begin
        prescaler   <= prescaler_next;
        time_digits <= time_digits_next;
        date_digits <= date_digits_next;
        tmr         <= tmr_next;
        out_valid   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (proc) begin
      out_data.time_out      <= time_digits_next;
      out_data.date_out      <= date_digits_next;
      out_data.timer_fired   <= fired;
      out_data.timer_running <= tmr_next.on;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, out_data};

endmodule

// ===== tb/bcd_rtc_calendar_timer_top_tb.sv =====
// ----------------------------------------------------------------------------
// bcd_rtc_calendar_timer_top_tb : self-checking bench for the BCD clock/timer
// Streams tick, time, date and timer operations into the block, predicts each
// status transaction in step with acceptance, and checks every field on the
// output stream against the oldest prediction.
// ----------------------------------------------------------------------------
module bcd_rtc_calendar_timer_top_tb;
  import bcd_rtc_pkg::*;

  localparam int N_RANDOM     = 1350;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;   // drain margin after the last status transaction

  // one queued operation: selector plus its payload fields
  typedef struct packed {
    op_t   op;
    item_t f;
  } rtc_op_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  rtc_op_t pending_ops[$];      // stimulus not yet offered
  result_t expected_status[$];  // predicted status transactions, oldest first
  int      total_items    = 0;
  int      items_accepted = 0;
  int      mismatches     = 0;

  // predictor state
  logic [PRESCALE_W-1:0] rtc_presc;
  logic [23:0]           rtc_time;
  logic [23:0]           rtc_date;
  tmr_state_t            rtc_tmr;

  always #5 clk = ~clk;

  bcd_rtc_calendar_timer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Digit increment, wrapping modulo 16; carry (and clear) only on an exact
  // match with the limit. A limit of 16 therefore never carries.
  function automatic logic [4:0] digit_inc(input logic [3:0] d, input int lim);
    logic [3:0] v;
    v = d + 4'd1;
    if (int'(v) == lim)
      return {1'b1, 4'd0};
    return {1'b0, v};
  endfunction

  // One second forward, carrying through time, day, month and year.
  task automatic advance_second();
    logic [23:0] t;
    logic [23:0] d;
    logic [4:0]  r;
    int          hour;
    int          month;
    int          days;
    int          day;
    t = rtc_time;
    d = rtc_date;
    r = digit_inc(t[3:0], 10); t[3:0] = r[3:0];
    if (r[4]) begin
      r = digit_inc(t[7:4], 6); t[7:4] = r[3:0];
      if (r[4]) begin
        r = digit_inc(t[11:8], 10); t[11:8] = r[3:0];
        if (r[4]) begin
          r = digit_inc(t[15:12], 6); t[15:12] = r[3:0];
          if (r[4]) begin
            r = digit_inc(t[19:16], 10); t[19:16] = r[3:0];
            if (r[4]) begin
              r = digit_inc(t[23:20], 16); t[23:20] = r[3:0];
            end
            hour = int'(t[19:16]) + int'(t[23:20]) * 10;
            // midnight: only an exact 24 rolls the day
            if (hour == 24) begin
              t[23:16] = 8'h00;
              month = int'(d[11:8]) + int'(d[15:12]) * 10;
              case (month)
                1, 3, 5, 7, 8, 10, 12: days = 31;
                2:                     days = 28;
                default:               days = 30;  // incl. invalid months
              endcase
              r = digit_inc(d[3:0], 10); d[3:0] = r[3:0];
              if (r[4]) begin
                r = digit_inc(d[7:4], 16); d[7:4] = r[3:0];
              end
              day = int'(d[3:0]) + int'(d[7:4]) * 10;
              if (day == days + 1) begin
                d[7:0] = 8'h01;
                r = digit_inc(d[11:8], 10); d[11:8] = r[3:0];
                if (r[4]) begin
                  r = digit_inc(d[15:12], 16); d[15:12] = r[3:0];
                end
                month = int'(d[11:8]) + int'(d[15:12]) * 10;
                if (month == 13) begin
                  d[15:8] = 8'h01;
                  r = digit_inc(d[19:16], 10); d[19:16] = r[3:0];
                  if (r[4]) begin
                    r = digit_inc(d[23:20], 10); d[23:20] = r[3:0];
                  end
                end
              end
            end
          end
        end
      end
    end
    rtc_time = t;
    rtc_date = d;
  endtask

  // Apply one accepted operation and queue the status it should produce.
  task automatic predict_status(input rtc_op_t x);
    result_t     status;
    logic        fired;
    int unsigned nxt;
    fired = 1'b0;
    case (x.op)
      OP_TICK: begin
        // timer first, then the prescaler
        if (rtc_tmr.on) begin
          rtc_tmr.count = rtc_tmr.count + 32'd1;
          if (rtc_tmr.count == rtc_tmr.target) begin
            rtc_tmr.count = '0;
            if (!rtc_tmr.periodic)
              rtc_tmr.on = 1'b0;
            fired = 1'b1;
          end
        end
        nxt = int'(rtc_presc) + 1;
        if (nxt >= PRESCALE_PERIOD) begin
          rtc_presc = '0;
          advance_second();
        end else begin
          rtc_presc = nxt[PRESCALE_W-1:0];
        end
      end
      OP_SET_TIME: begin
        rtc_time  = x.f.time_in;
        rtc_presc = x.f.prescale_start;
      end
      OP_SET_DATE: begin
        rtc_date = x.f.date_in;
      end
      default: begin
        rtc_tmr.target   = x.f.target_in;
        rtc_tmr.on       = x.f.enable_in;
        rtc_tmr.periodic = x.f.retrigger_in;
        rtc_tmr.count    = '0;
      end
    endcase
    status.time_out      = rtc_time;
    status.date_out      = rtc_date;
    status.timer_fired   = fired;
    status.timer_running = rtc_tmr.on;
    expected_status.push_back(status);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Random payload: fields unused by an operation still toggle.
  function automatic item_t rand_item();
    logic [127:0] raw;
    item_t        f;
    raw = {$urandom, $urandom, $urandom, $urandom};
    f   = raw[ITEM_W-1:0];
    return f;
  endfunction

  function automatic logic [7:0] bcd2(input int n);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'(n / 10);
    lo = 4'(n % 10);
    return {hi, lo};
  endfunction

  task automatic push_op(input op_t op, input item_t f);
    rtc_op_t x;
    x.op = op;
    x.f  = f;
    pending_ops.push_back(x);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_op(OP_TICK, rand_item());
  endtask

  task automatic push_set_time(input logic [23:0] t, input logic [14:0] p);
    item_t f;
    f = rand_item();
    f.time_in        = t;
    f.prescale_start = p;
    push_op(OP_SET_TIME, f);
  endtask

  task automatic push_set_date(input logic [23:0] d);
    item_t f;
    f = rand_item();
    f.date_in = d;
    push_op(OP_SET_DATE, f);
  endtask

  task automatic push_set_timer(input logic [31:0] target, input logic en,
                                input logic per);
    item_t f;
    f = rand_item();
    f.target_in    = target;
    f.enable_in    = en;
    f.retrigger_in = per;
    push_op(OP_SET_TIMER, f);
  endtask

  // Idle/stall percentage by phase: sender-light first, receiver-light next,
  // then back-to-back.
  function automatic int idle_pct(input int done, input bit receiver);
    if (done * 3 < total_items)
      return receiver ? 82 : 26;
    if (done * 3 < total_items * 2)
      return receiver ? 26 : 82;
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued operations, predicts on each accepted transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rtc_op_t nxt_op;
    rtc_op_t cur_op;
    if (rst) begin
      s_axis_tvalid  <= 1'b0;
      items_accepted <= 0;
      rtc_presc       = '0;
      rtc_time        = '0;
      rtc_date        = '0;
      rtc_tmr         = '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        // predict from what actually sat on the bus at this edge
        cur_op.op = op_t'(s_axis_tuser);
        cur_op.f  = s_axis_tdata[ITEM_W-1:0];
        predict_status(cur_op);
        items_accepted <= items_accepted + 1;
      end
      if (pending_ops.size() != 0 &&
          $urandom_range(99) >= idle_pct(items_accepted, 1'b0)) begin
        nxt_op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt_op.op;
        s_axis_tdata  <= {{(S_TDATA_W - ITEM_W){1'b0}}, nxt_op.f};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, field-by-field compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct(items_accepted, 1'b1));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[RESULT_W-1:0];
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected status transaction: time %h date %h fired %b run %b",
                     got.time_out, got.date_out, got.timer_fired, got.timer_running);
        end else begin
          want = expected_status.pop_front();
          if (got.time_out      !== want.time_out      ||
              got.date_out      !== want.date_out      ||
              got.timer_fired   !== want.timer_fired   ||
              got.timer_running !== want.timer_running) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("status mismatch: time %h/%h date %h/%h fired %b/%b run %b/%b (exp/act)",
                       want.time_out, got.time_out, want.date_out, got.date_out,
                       want.timer_fired, got.timer_fired,
                       want.timer_running, got.timer_running);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int target_len;
    int hh;
    int mm;
    int ss;
    logic [14:0] pstart;

    // directed: tick straight out of reset
    push_ticks(1);
    // midnight rollover with an invalid (zero) month
    push_set_time(24'h235959, 15'h7FFF);
    push_ticks(1);
    // end of year, year wraps to 00
    push_set_date(24'h991231);
    push_set_time(24'h235959, 15'h7FFF);
    push_ticks(1);
    // end of February, no leap day
    push_set_date(24'h230228);
    push_set_time(24'h235959, 15'h7FFF);
    push_ticks(1);
    // non-BCD date digits at midnight
    push_set_date(24'hFFFFFF);
    push_set_time(24'h235959, 15'h7FFF);
    push_ticks(1);
    // non-BCD time digits wrap without carry
    push_set_time(24'hFFFFFF, 15'h7FFF);
    push_ticks(1);
    // periodic timer firing every tick
    push_set_timer(32'd1, 1'b1, 1'b1);
    push_ticks(2);
    // one-shot timer stops after firing
    push_set_timer(32'd2, 1'b1, 1'b0);
    push_ticks(3);
    // zero target never reached in a short run
    push_set_timer(32'd0, 1'b1, 1'b1);
    push_ticks(1);
    // full-scale target, disabled
    push_set_timer(32'hFFFF_FFFF, 1'b0, 1'b0);

    target_len = pending_ops.size() + N_RANDOM;
    while (pending_ops.size() < target_len) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          // well-formed: calendar near a boundary, clock about to tick over
          if ($urandom_range(2) != 0)
            push_set_date({bcd2($urandom_range(99)), bcd2($urandom_range(1, 12)),
                           bcd2($urandom_range(27, 31))});
          hh = ($urandom_range(3) == 0) ? $urandom_range(23) : 23;
          mm = ($urandom_range(3) == 0) ? $urandom_range(59) : 59;
          ss = ($urandom_range(1) == 0) ? 59 : $urandom_range(55, 59);
          pstart = ($urandom_range(4) == 0) ? 15'($urandom_range(32767))
                                            : 15'($urandom_range(32760, 32767));
          push_set_time({bcd2(hh), bcd2(mm), bcd2(ss)}, pstart);
          if ($urandom_range(1) != 0)
            push_set_timer($urandom_range(1, 6), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
          push_ticks($urandom_range(1, 12));
        end
        6: begin
          // noise: any operation with raw field values
          push_op(op_t'($urandom_range(3)), rand_item());
        end
        7, 8: begin
          push_ticks($urandom_range(1, 20));
        end
        default: begin
          // broken sequence: raw time then a few ticks
          push_set_time(24'($urandom), 15'($urandom));
          push_ticks($urandom_range(1, 4));
        end
      endcase
    end
    total_items = pending_ops.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < total_items) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_status.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/bcd_rtc_pkg.sv
design/bcd_rtc_cal.sv
design/bcd_rtc_tmr.sv
design/bcd_rtc_calendar_timer_top.sv
tb/bcd_rtc_calendar_timer_top_tb.sv
